/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 3;
    localparam int STS_W    = 3;

    localparam int IN_TDATA_W  = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W   = WORD_W + POS_W + STS_W + CW + 1;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ   = 3'd6;

    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_EMPTY    = 3'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STS_W-1:0] STS_BADIDX   = 3'd3;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch;
        logic setup;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

/* rtl/indexed_list_store_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Bits  Contents (low bit up)
// s_axis   in   40    tdata: position[5:0], word_in[37:6]; tuser: op[2:0]
// m_axis   out  56    tdata: word_out[31:0], found_at[37:32], status[40:38],
//                            count[47:41], list_empty[48]
//
// One item at a time. Push, undefined ops and any error make no reads of the list
// memory, which has one read and one write port; the other ops read it: pop/read
// once, insert count-pos times, delete count-pos-1, remove/find count times.
// Reset (synchronous, active low) empties the list; memory is not cleared.
// A result stalled on m_axis holds; the next item is still taken meanwhile and
// waits before its result until the output register frees up.

module indexed_list_store_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ils_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // position, word_in
    input  logic [ils_pkg::OP_W-1:0]          s_axis_tuser,  // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ils_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // word_out, found_at, status,
                                                             // count, list_empty
);

    ils_pkg::t_cmd  cmd;
    ils_pkg::t_stat stat;

    logic [ils_pkg::WORD_W-1:0] word_out;
    logic [ils_pkg::POS_W-1:0]  found_at;
    logic [ils_pkg::STS_W-1:0]  status;
    logic [ils_pkg::CW-1:0]     count;
    logic                       list_empty;

    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ils_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (s_axis_tuser),
        .i_position   (s_axis_tdata[ils_pkg::POS_W-1:0]),
        .i_word_in    (s_axis_tdata[ils_pkg::POS_W +: ils_pkg::WORD_W]),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_word_out   (word_out),
        .o_found_at   (found_at),
        .o_status     (status),
        .o_count      (count),
        .o_list_empty (list_empty)
    );

    assign m_axis_tdata = {{(ils_pkg::OUT_TDATA_W - ils_pkg::OUT_FLD_W){1'b0}},
                           list_empty, count, status, found_at, word_out};

endmodule

/* rtl/ils_ctrl.sv */
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  ils_pkg::t_stat i_stat,
    output ils_pkg::t_cmd  o_cmd
);

    ils_pkg::t_state r_state;
    ils_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ils_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ils_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ils_pkg::S_DECODE;
                end
            end
            ils_pkg::S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state     = ils_pkg::S_SCAN;
            end
            ils_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ils_pkg::S_FINISH;
                end
            end
            ils_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ils_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ils_pkg::S_IDLE;
            end
        endcase
    end

    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("finish issued while output slot busy");

    a_decode_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ils_pkg::S_DECODE) |-> $past(i_s_tvalid && o_s_tready))
        else $error("decode without an accepted transfer");

endmodule

/* rtl/ils_dp.sv */
`timescale 1ns / 1ps

module ils_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ils_pkg::t_cmd                i_cmd,
    output ils_pkg::t_stat               o_stat,
    input  logic [ils_pkg::OP_W-1:0]     i_op,
    input  logic [ils_pkg::POS_W-1:0]    i_position,
    input  logic [ils_pkg::WORD_W-1:0]   i_word_in,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [ils_pkg::WORD_W-1:0]   o_word_out,
    output logic [ils_pkg::POS_W-1:0]    o_found_at,
    output logic [ils_pkg::STS_W-1:0]    o_status,
    output logic [ils_pkg::CW-1:0]       o_count,
    output logic                         o_list_empty
);

    logic [ils_pkg::WORD_W-1:0] r_mem [ils_pkg::CAPACITY];

    logic [ils_pkg::OP_W-1:0]   r_op;
    logic [ils_pkg::POS_W-1:0]  r_pos;
    logic [ils_pkg::WORD_W-1:0] r_word;
    logic [ils_pkg::CW-1:0]     r_count;
    logic [ils_pkg::CW-1:0]     r_left;
    logic [ils_pkg::CW-1:0]     r_rd_idx;
    logic                       r_pend;
    logic [ils_pkg::AW-1:0]     r_pend_idx;
    logic [ils_pkg::WORD_W-1:0] r_rdata;
    logic [ils_pkg::CW-1:0]     r_wr_ptr;
    logic                       r_found;
    logic [ils_pkg::AW-1:0]     r_found_at;
    logic [ils_pkg::WORD_W-1:0] r_word_out;
    logic [ils_pkg::STS_W-1:0]  r_status;

    logic                       r_out_valid;
    logic [ils_pkg::WORD_W-1:0] r_out_word;
    logic [ils_pkg::POS_W-1:0]  r_out_found;
    logic [ils_pkg::STS_W-1:0]  r_out_status;
    logic [ils_pkg::CW-1:0]     r_out_count;

    logic [ils_pkg::CW-1:0]     pos_c;
    logic [ils_pkg::STS_W-1:0]  err;
    logic [ils_pkg::CW-1:0]     scan_len;
    logic [ils_pkg::CW-1:0]     scan_start;
    logic                       issue;
    logic [ils_pkg::AW-1:0]     rd_addr;
    logic                       wr_en;
    logic [ils_pkg::AW-1:0]     wr_addr;
    logic [ils_pkg::WORD_W-1:0] wr_data;
    logic                       keep;
    logic [ils_pkg::CW-1:0]     n_count;
    logic [ils_pkg::STS_W-1:0]  n_status;
    logic [ils_pkg::WORD_W-1:0] n_word_out;
    logic [ils_pkg::POS_W-1:0]  n_found_at;
    logic                       out_free;

    assign pos_c   = ils_pkg::CW'(r_pos);
    assign issue   = i_cmd.scan && (r_left != '0);
    assign rd_addr = r_rd_idx[ils_pkg::AW-1:0];
    assign keep    = (r_rdata != r_word);
    assign out_free = !r_out_valid || i_m_tready;

    assign o_stat.scan_done = (r_left == '0) && !r_pend;
    assign o_stat.out_free  = out_free;

    // error checks, then the read sweep each op needs
    always_comb begin
        err        = ils_pkg::STS_OK;
        scan_len   = '0;
        scan_start = '0;
        unique case (r_op)
            ils_pkg::OP_PUSH: begin
                if (r_count >= ils_pkg::CW'(ils_pkg::CAPACITY)) begin
                    err = ils_pkg::STS_FULL;
                end
            end
            ils_pkg::OP_INSERT: begin
                if (pos_c > r_count) begin
                    err = ils_pkg::STS_BADIDX;
                end else if (r_count >= ils_pkg::CW'(ils_pkg::CAPACITY)) begin
                    err = ils_pkg::STS_FULL;
                end
                scan_len   = r_count - pos_c;
                scan_start = r_count - ils_pkg::CW'(1);
            end
            ils_pkg::OP_POP: begin
                if (r_count == '0) begin
                    err = ils_pkg::STS_EMPTY;
                end
                scan_len   = ils_pkg::CW'(1);
                scan_start = r_count - ils_pkg::CW'(1);
            end
            ils_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    err = ils_pkg::STS_EMPTY;
                end else if (pos_c >= r_count) begin
                    err = ils_pkg::STS_BADIDX;
                end
                scan_len   = r_count - pos_c - ils_pkg::CW'(1);
                scan_start = pos_c + ils_pkg::CW'(1);
            end
            ils_pkg::OP_REMOVE, ils_pkg::OP_FIND: begin
                if (r_count == '0) begin
                    err = ils_pkg::STS_EMPTY;
                end
                scan_len = r_count;
            end
            ils_pkg::OP_READ: begin
                if (r_count == '0) begin
                    err = ils_pkg::STS_EMPTY;
                end else if (pos_c >= r_count) begin
                    err = ils_pkg::STS_BADIDX;
                end
                scan_len   = ils_pkg::CW'(1);
                scan_start = pos_c;
            end
            default: begin
                err = ils_pkg::STS_OK;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rdata;
        if (r_pend) begin
            unique case (r_op)
                ils_pkg::OP_INSERT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx + ils_pkg::AW'(1);
                end
                ils_pkg::OP_DELETE: begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx - ils_pkg::AW'(1);
                end
                ils_pkg::OP_REMOVE: begin
                    wr_en   = keep;
                    wr_addr = r_wr_ptr[ils_pkg::AW-1:0];
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end else if (i_cmd.finish && (r_status == ils_pkg::STS_OK)) begin
            wr_data = r_word;
            if (r_op == ils_pkg::OP_PUSH) begin
                wr_en   = 1'b1;
                wr_addr = r_count[ils_pkg::AW-1:0];
            end else if (r_op == ils_pkg::OP_INSERT) begin
                wr_en   = 1'b1;
                wr_addr = ils_pkg::AW'(r_pos);
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_status   = r_status;
        n_word_out = '0;
        n_found_at = '0;
        if (r_status == ils_pkg::STS_OK) begin
            unique case (r_op)
                ils_pkg::OP_PUSH, ils_pkg::OP_INSERT: begin
                    n_count = r_count + ils_pkg::CW'(1);
                end
                ils_pkg::OP_POP: begin
                    n_count    = r_count - ils_pkg::CW'(1);
                    n_word_out = r_word_out;
                end
                ils_pkg::OP_DELETE: begin
                    n_count = r_count - ils_pkg::CW'(1);
                end
                ils_pkg::OP_REMOVE: begin
                    n_count = r_wr_ptr;
                    if (r_wr_ptr == r_count) begin
                        n_status = ils_pkg::STS_NOTFOUND;
                    end
                end
                ils_pkg::OP_FIND: begin
                    if (r_found) begin
                        n_found_at = ils_pkg::POS_W'(r_found_at);
                    end else begin
                        n_status = ils_pkg::STS_NOTFOUND;
                    end
                end
                ils_pkg::OP_READ: begin
                    n_word_out = r_word_out;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= issue;
            if (i_cmd.setup) begin
                r_left <= (err == ils_pkg::STS_OK) ? scan_len : '0;
            end else if (issue) begin
                r_left <= r_left - ils_pkg::CW'(1);
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_op;
            r_pos  <= i_position;
            r_word <= i_word_in;
        end
        if (i_cmd.setup) begin
            r_status   <= err;
            r_rd_idx   <= scan_start;
            r_wr_ptr   <= '0;
            r_found    <= 1'b0;
            r_found_at <= '0;
            r_word_out <= '0;
        end
        if (issue) begin
            r_pend_idx <= rd_addr;
            if (r_op == ils_pkg::OP_INSERT) begin
                r_rd_idx <= r_rd_idx - ils_pkg::CW'(1);
            end else begin
                r_rd_idx <= r_rd_idx + ils_pkg::CW'(1);
            end
        end
        if (r_pend) begin
            if (r_op == ils_pkg::OP_REMOVE && keep) begin
                r_wr_ptr <= r_wr_ptr + ils_pkg::CW'(1);
            end
            if (r_op == ils_pkg::OP_FIND && !keep && !r_found) begin
                r_found    <= 1'b1;
                r_found_at <= r_pend_idx;
            end
            if (r_op == ils_pkg::OP_POP || r_op == ils_pkg::OP_READ) begin
                r_word_out <= r_rdata;
            end
        end
        if (i_cmd.finish) begin
            r_out_word   <= n_word_out;
            r_out_found  <= n_found_at;
            r_out_status <= n_status;
            r_out_count  <= n_count;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_word_out   = r_out_word;
    assign o_found_at   = r_out_found;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_list_empty = (r_out_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ils_pkg::CW'(ils_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && wr_en) |-> (wr_addr != rd_addr))
        else $error("shift write hits the address being read");

endmodule
